@@ src/bsw_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the bcd stopwatch with alarms
package bsw_pkg;

	// operation codes of a command transaction
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_NEW_ALARM  = 2'd1,
		OP_RESET_TIME = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALE_LIMIT = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ENABLE     = 4'd1;

	// reset values of the configuration registers
	localparam logic [7:0] PRESCALE_LIMIT_RST = 8'd2;
	localparam logic       RUN_ENABLE_RST     = 1'b1;

	// digit limits
	localparam logic [3:0] DIGIT_MAX    = 4'd9;
	localparam logic [2:0] SEC_TENS_MAX = 3'd5;

	// last state of the button delay before the press counter advances
	localparam logic [1:0] BTN_DELAY_LAST = 2'd3;
	localparam logic [1:0] BTN_DELAY_ARM  = 2'd1;

	// number of slots shown on the expired mask
	localparam int unsigned MASK_W = 3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] alarm_secs;
		logic        button_press;
	} cmd_t;

	typedef struct packed {
		logic [3:0] tenths;
		logic [3:0] secs_ones;
		logic [2:0] secs_tens;
		logic [3:0] mins_ones;
		logic [3:0] mins_tens;
	} digits_t;

	// what the time base shows after one transaction
	typedef struct packed {
		digits_t    digits;
		logic [3:0] button_total;
		logic       square_out;
		logic       sec_pulse;
	} tb_view_t;

	// what the alarm bank shows after one transaction
	typedef struct packed {
		logic [MASK_W-1:0] expired_mask;
		logic              alarm_fired;
		logic              alarm_accepted;
		logic [1:0]        alarm_slot;
	} alarm_view_t;

	typedef struct packed {
		logic [3:0]        tenths;
		logic [3:0]        secs_ones;
		logic [2:0]        secs_tens;
		logic [3:0]        mins_ones;
		logic [3:0]        mins_tens;
		logic [MASK_W-1:0] expired_mask;
		logic              alarm_fired;
		logic              alarm_accepted;
		logic [1:0]        alarm_slot;
		logic [3:0]        button_total;
		logic              square_out;
	} res_t;

endpackage

@@ src/bsw_if.sv @@
`timescale 1ns / 1ps
// handshake interfaces for the command, result and configuration channels
interface bsw_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bsw_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bsw_pkg::CFG_INDEX_W-1:0]   index;
	logic [bsw_pkg::CFG_DATA_W-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ src/bsw_timebase.sv @@
`timescale 1ns / 1ps
// prescaler, bcd digit chain, square output and delayed button counter
module bsw_timebase (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  bsw_pkg::cmd_t     cmd,
	input  logic [7:0]        prescale_limit,
	input  logic              run_enable,
	output bsw_pkg::tb_view_t view
);
	import bsw_pkg::*;

	logic [7:0] presc_q;
	logic [7:0] presc_n;
	digits_t    dig_q;
	digits_t    dig_n;
	logic       square_q;
	logic       square_n;
	logic [1:0] delay_q;
	logic [1:0] delay_arm;
	logic [1:0] delay_n;
	logic [3:0] btn_q;
	logic [3:0] btn_n;
	logic       tick_run;
	logic       tenth_adv;
	logic       sec_adv;

	assign tick_run = (op_t'(cmd.operation) == OP_TICK) && run_enable;

	// prescaler and square level
	always_comb begin
		presc_n   = presc_q;
		square_n  = square_q;
		tenth_adv = 1'b0;
		if (tick_run) begin
			if (presc_q < prescale_limit) begin
				presc_n = presc_q + 8'd1;
			end else begin
				presc_n   = '0;
				square_n  = ~square_q;
				tenth_adv = 1'b1;
			end
		end
	end

	// cascaded bcd digits, cleared by a reset-time operation
	always_comb begin
		dig_n   = dig_q;
		sec_adv = 1'b0;
		if (op_t'(cmd.operation) == OP_RESET_TIME) begin
			dig_n = '0;
		end else if (tenth_adv) begin
			if (dig_q.tenths == DIGIT_MAX) begin
				dig_n.tenths = '0;
				sec_adv      = 1'b1;
				if (dig_q.secs_ones == DIGIT_MAX) begin
					dig_n.secs_ones = '0;
					if (dig_q.secs_tens == SEC_TENS_MAX) begin
						dig_n.secs_tens = '0;
						if (dig_q.mins_ones == DIGIT_MAX) begin
							dig_n.mins_ones = '0;
							if (dig_q.mins_tens == DIGIT_MAX) begin
								dig_n.mins_tens = '0;
							end else begin
								dig_n.mins_tens = dig_q.mins_tens + 4'd1;
							end
						end else begin
							dig_n.mins_ones = dig_q.mins_ones + 4'd1;
						end
					end else begin
						dig_n.secs_tens = dig_q.secs_tens + 3'd1;
					end
				end else begin
					dig_n.secs_ones = dig_q.secs_ones + 4'd1;
				end
			end else begin
				dig_n.tenths = dig_q.tenths + 4'd1;
			end
		end
	end

	// button delay: arm first, then advance on a running tick
	always_comb begin
		delay_arm = (cmd.button_press && (delay_q == '0)) ? BTN_DELAY_ARM : delay_q;
		delay_n   = delay_arm;
		btn_n     = btn_q;
		if (tick_run && (delay_arm != '0)) begin
			if (delay_arm < BTN_DELAY_LAST) begin
				delay_n = delay_arm + 2'd1;
			end else begin
				delay_n = '0;
				btn_n   = btn_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q  <= '0;
			dig_q    <= '0;
			square_q <= 1'b0;
			delay_q  <= '0;
			btn_q    <= '0;
		end else if (adv) begin
			presc_q  <= presc_n;
			dig_q    <= dig_n;
			square_q <= square_n;
			delay_q  <= delay_n;
			btn_q    <= btn_n;
		end
	end

	assign view.digits       = dig_n;
	assign view.button_total = btn_n;
	assign view.square_out   = square_n;
	assign view.sec_pulse    = sec_adv;

endmodule

@@ src/bsw_alarm_bank.sv @@
`timescale 1ns / 1ps
// countdown alarm slots: allocation, per-second decrement and expiry marks
module bsw_alarm_bank #(
	parameter int unsigned NUM_ALARMS  = 3,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  bsw_pkg::cmd_t        cmd,
	input  logic                 sec_pulse,
	output bsw_pkg::alarm_view_t view
);
	import bsw_pkg::*;

	localparam int unsigned SLOT_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

	logic [NUM_ALARMS-1:0]  active_q;
	logic [NUM_ALARMS-1:0]  active_n;
	logic [NUM_ALARMS-1:0]  expired_q;
	logic [NUM_ALARMS-1:0]  expired_n;
	logic [NUM_ALARMS-1:0]  alloc_sel;
	logic [NUM_ALARMS-1:0]  expiring;
	logic [COUNT_WIDTH-1:0] count_q [NUM_ALARMS];
	logic [COUNT_WIDTH-1:0] count_n [NUM_ALARMS];
	logic [COUNT_WIDTH-1:0] load_val;
	logic [COUNT_WIDTH+15:0] dur_ext;
	logic                   fired_q;
	logic                   fired_n;
	logic                   found;
	logic [SLOT_W-1:0]      slot;
	logic [SLOT_W+1:0]      slot_ext;
	logic                   new_op;
	logic                   clear_op;

	assign new_op   = (op_t'(cmd.operation) == OP_NEW_ALARM);
	assign clear_op = (op_t'(cmd.operation) == OP_CLEAR);
	assign dur_ext  = {{COUNT_WIDTH{1'b0}}, cmd.alarm_secs};
	assign load_val = dur_ext[COUNT_WIDTH-1:0];

	// lowest inactive slot
	always_comb begin
		alloc_sel = '0;
		found     = 1'b0;
		slot      = '0;
		for (int i = 0; i < NUM_ALARMS; i++) begin
			if (!active_q[i] && !found) begin
				alloc_sel[i] = new_op;
				found        = 1'b1;
				slot         = SLOT_W'(i);
			end
		end
	end

	// per-slot next state
	always_comb begin
		for (int i = 0; i < NUM_ALARMS; i++) begin
			count_n[i]   = count_q[i];
			expiring[i]  = 1'b0;
			active_n[i]  = active_q[i] | alloc_sel[i];
			expired_n[i] = clear_op ? 1'b0 : expired_q[i];
			if (alloc_sel[i]) begin
				count_n[i] = load_val;
			end else if (sec_pulse && active_q[i] && !expired_q[i]) begin
				count_n[i]  = count_q[i] - COUNT_WIDTH'(1);
				expiring[i] = (count_n[i] == '0);
			end
			if (expiring[i]) begin
				expired_n[i] = 1'b1;
			end
		end
		fired_n = clear_op ? 1'b0 : (fired_q | (|expiring));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			expired_q <= '0;
			fired_q   <= 1'b0;
		end else if (adv) begin
			active_q  <= active_n;
			expired_q <= expired_n;
			fired_q   <= fired_n;
		end
	end

	// counts hold no reset: a slot is loaded before it is ever read
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_ALARMS; i++) begin
				count_q[i] <= count_n[i];
			end
		end
	end

	// expired mask shows the first slots only
	genvar g;
	generate
		for (g = 0; g < MASK_W; g++) begin : g_mask
			if (g < NUM_ALARMS) begin : g_on
				assign view.expired_mask[g] = expired_n[g];
			end else begin : g_off
				assign view.expired_mask[g] = 1'b0;
			end
		end
	endgenerate

	assign slot_ext            = {2'b00, slot};
	assign view.alarm_fired    = fired_n;
	assign view.alarm_accepted = new_op && found;
	assign view.alarm_slot     = (new_op && found) ? slot_ext[1:0] : 2'b00;

endmodule

@@ src/bcd_stopwatch_with_alarms.sv @@
`timescale 1ns / 1ps
// Top level of the bcd stopwatch with countdown alarms and button counter.
// Every command transaction gives exactly one result transaction that shows
// the state after that command. Throughput is one command per clock cycle
// while results are taken. The command is captured in an input register,
// then the time base and alarm bank update their state and load the result
// register. A waiting result blocks the pipeline only once the input
// register is also full. Configuration writes are always ready and should be
// issued only while no command is in flight.
module bcd_stopwatch_with_alarms #(
	parameter int unsigned NUM_ALARMS  = 3,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	bsw_stream_if.sink   cmd,
	bsw_stream_if.source res,
	bsw_cfg_if.sink      cfg
);
	import bsw_pkg::*;

	cmd_t        cmd_s1;
	logic        valid_s1;
	res_t        res_q;
	logic        res_valid_q;
	logic        adv;
	logic [7:0]  limit_q;
	logic        run_q;
	tb_view_t    tb_view;
	alarm_view_t al_view;

	// pipeline control
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= PRESCALE_LIMIT_RST;
			run_q   <= RUN_ENABLE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PRESCALE_LIMIT: limit_q <= cfg.wdata;
				CFG_RUN_ENABLE:     run_q   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	bsw_timebase u_timebase (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.cmd            (cmd_s1),
		.prescale_limit (limit_q),
		.run_enable     (run_q),
		.view           (tb_view)
	);

	bsw_alarm_bank #(
		.NUM_ALARMS  (NUM_ALARMS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_alarm_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cmd       (cmd_s1),
		.sec_pulse (tb_view.sec_pulse),
		.view      (al_view)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.tenths         <= tb_view.digits.tenths;
			res_q.secs_ones      <= tb_view.digits.secs_ones;
			res_q.secs_tens      <= tb_view.digits.secs_tens;
			res_q.mins_ones      <= tb_view.digits.mins_ones;
			res_q.mins_tens      <= tb_view.digits.mins_tens;
			res_q.expired_mask   <= al_view.expired_mask;
			res_q.alarm_fired    <= al_view.alarm_fired;
			res_q.alarm_accepted <= al_view.alarm_accepted;
			res_q.alarm_slot     <= al_view.alarm_slot;
			res_q.button_total   <= tb_view.button_total;
			res_q.square_out     <= tb_view.square_out;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

@@ src/bsw_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the stopwatch results, bound to the top level
module bsw_checker #(
	parameter int unsigned NUM_ALARMS = 3
) (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input bsw_pkg::res_t res_data
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// digits stay in bcd range
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.tenths <= 4'd9) && (res_data.secs_ones <= 4'd9) &&
			(res_data.secs_tens <= 3'd5) && (res_data.mins_ones <= 4'd9) &&
			(res_data.mins_tens <= 4'd9))
		else $error("digit out of range");

	// an expired slot always goes with the fired flag
	a_fired: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.expired_mask != '0) |-> res_data.alarm_fired)
		else $error("expired slot without fired flag");

	// slot index is zero unless taken; when taken it is within the slot count, unless there are more than four slots
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.alarm_accepted ?
			(32'(res_data.alarm_slot) < NUM_ALARMS) || (NUM_ALARMS > 4) :
			(res_data.alarm_slot == 2'd0)))
		else $error("bad alarm slot");

endmodule

bind bcd_stopwatch_with_alarms bsw_checker #(
	.NUM_ALARMS (NUM_ALARMS)
) u_bsw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
